// ===== rtl/core/nlc_pkg.sv =====
`default_nettype none

package nlc_pkg;

    localparam int CHAR_W      = 8;
    localparam int CLASS_W     = 2;
    localparam int VALUE_W     = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CLASS_W - VALUE_W;

    // Magnitude holds up to 2^31, so it needs the full value width.
    localparam int MAG_W = VALUE_W;
    // Width of magnitude * 10 + digit before saturation.
    localparam int ACC_W = MAG_W + 4;

    localparam logic [MAG_W-1:0] MAG_LIMIT   = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;

    localparam logic [CHAR_W-1:0] CHAR_TERM  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_EXP_L = 8'h65;
    localparam logic [CHAR_W-1:0] CHAR_EXP_U = 8'h45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [CLASS_W-1:0] CLASS_TEXT    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_INTEGER = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_DECIMAL = 2'd2;

    typedef struct packed {
        logic [CLASS_W-1:0]        value_class;
        logic signed [VALUE_W-1:0] int_value;
    } result_t;

    typedef struct packed {
        logic                valid;
        logic [CHAR_W-1:0]   char_code;
    } char_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/nlc_in_reg.sv =====
`default_nettype none

module nlc_in_reg
    import nlc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic                  advance,
    output char_word_t                 word
);

    logic              valid_reg;
    logic [CHAR_W-1:0] char_reg;

    // The held word moves on when the recognizer consumes it, so a new word
    // can enter in the same cycle.
    assign s_tready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            char_reg <= s_tdata[CHAR_W-1:0];
        end
    end

    assign word.valid     = valid_reg;
    assign word.char_code = char_reg;

endmodule

`default_nettype wire

// ===== rtl/core/nlc_recognizer.sv =====
`default_nettype none

module nlc_recognizer
    import nlc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [CHAR_W-1:0] char_code,
    output result_t                result
);

    typedef enum logic [3:0] {
        ST_START   = 4'd0,
        ST_SIGN    = 4'd1,
        ST_INT     = 4'd2,
        ST_POINT   = 4'd3,
        ST_FRAC    = 4'd4,
        ST_EXP     = 4'd5,
        ST_EXPSIGN = 4'd6,
        ST_EXPDIG  = 4'd7,
        ST_DEAD    = 4'd8
    } rec_state_t;

    rec_state_t       state_reg, state_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             neg_reg, neg_next;

    logic             is_digit, is_sign, is_dot, is_exp, is_term;
    logic [3:0]       digit;
    logic [ACC_W-1:0] acc;
    logic [MAG_W-1:0] mag_acc;

    assign is_term    = (char_code == CHAR_TERM);
    assign is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign is_sign    = (char_code == CHAR_MINUS) || (char_code == CHAR_PLUS);
    assign is_dot     = (char_code == CHAR_DOT);
    assign is_exp     = (char_code == CHAR_EXP_L) || (char_code == CHAR_EXP_U);
    assign digit      = char_code[3:0] - CHAR_ZERO[3:0];

    // magnitude * 10 + digit as two shifted adds, saturated at 2^31.
    assign acc = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
               + {{(ACC_W-4){1'b0}}, digit};
    assign mag_acc = (acc > {4'b0000, MAG_LIMIT}) ? MAG_LIMIT : acc[MAG_W-1:0];

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        if (is_term) begin
            state_next = ST_START;
            mag_next   = '0;
            neg_next   = 1'b0;
        end else begin
            unique case (state_reg)
                ST_START: begin
                    if (is_sign) begin
                        neg_next   = (char_code == CHAR_MINUS);
                        state_next = ST_SIGN;
                    end else if (is_digit) begin
                        mag_next   = mag_acc;
                        state_next = ST_INT;
                    end else begin
                        state_next = ST_DEAD;
                    end
                end
                ST_SIGN: begin
                    if (is_digit) begin
                        mag_next   = mag_acc;
                        state_next = ST_INT;
                    end else if (is_dot) begin
                        state_next = ST_POINT;
                    end else begin
                        state_next = ST_DEAD;
                    end
                end
                ST_INT: begin
                    if (is_digit) begin
                        mag_next   = mag_acc;
                        state_next = ST_INT;
                    end else if (is_dot) begin
                        state_next = ST_POINT;
                    end else if (is_exp) begin
                        state_next = ST_EXP;
                    end else begin
                        state_next = ST_DEAD;
                    end
                end
                ST_POINT: begin
                    state_next = is_digit ? ST_FRAC : ST_DEAD;
                end
                ST_FRAC: begin
                    if (is_digit) begin
                        state_next = ST_FRAC;
                    end else if (is_exp) begin
                        state_next = ST_EXP;
                    end else begin
                        state_next = ST_DEAD;
                    end
                end
                ST_EXP: begin
                    if (is_sign) begin
                        state_next = ST_EXPSIGN;
                    end else if (is_digit) begin
                        state_next = ST_EXPDIG;
                    end else begin
                        state_next = ST_DEAD;
                    end
                end
                ST_EXPSIGN, ST_EXPDIG: begin
                    state_next = is_digit ? ST_EXPDIG : ST_DEAD;
                end
                default: begin
                    state_next = ST_DEAD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_START;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
        end else if (step) begin
            state_reg <= state_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
        end
    end

    // Result as seen at a terminator, from the state the token left behind.
    always_comb begin
        result.value_class = CLASS_TEXT;
        result.int_value   = '0;
        if (state_reg == ST_INT) begin
            result.value_class = CLASS_INTEGER;
            if (neg_reg) begin
                result.int_value = -mag_reg;
            end else if (mag_reg >= MAG_LIMIT) begin
                result.int_value = POS_LIMIT;
            end else begin
                result.int_value = mag_reg;
            end
        end else if (state_reg == ST_FRAC || state_reg == ST_EXPDIG) begin
            result.value_class = CLASS_DECIMAL;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nlc_out_reg.sv =====
`default_nettype none

module nlc_out_reg
    import nlc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire result_t                result,
    output logic                        room,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic    valid_reg;
    result_t data_reg;

    assign room = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (room) begin
            valid_reg <= load;
        end
        if (load && room) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, data_reg.int_value, data_reg.value_class};

endmodule

`default_nettype wire

// ===== rtl/core/numeric_literal_classifier.sv =====
// A terminator word waits in the input register until the result register has room;
// it is then classified and its result is loaded into the result register.
// Throughput: one character word per cycle while no terminator waits for room in
// the result register, set by the recognizer update and its magnitude * 10 + digit accumulate.
// Reset: aresetn is synchronous and active low; it empties both registers and
// returns the recognizer to its start state with a zero magnitude and sign.
`default_nettype none

module numeric_literal_classifier
    import nlc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // s_tdata: [7:0] char_code.
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // m_tdata: [1:0] value_class, [33:2] int_value, [39:34] zero.
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    char_word_t word;
    result_t    result;
    logic       advance;
    logic       is_term;
    logic       out_room;
    logic       out_load;

    // The input register holds one character word. An ordinary character
    // only updates the recognizer, so it moves on at once; a terminator
    // also needs room in the result register, which frees up in the same
    // cycle that the downstream side takes the pending result.
    nlc_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .word     (word)
    );

    assign is_term  = (word.char_code == CHAR_TERM);
    assign advance  = word.valid && (!is_term || out_room);
    assign out_load = advance && is_term;

    // Recognizer state, integer magnitude and sign; a terminator step
    // clears them back to the start state.
    nlc_recognizer u_recognizer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .char_code (word.char_code),
        .result    (result)
    );

    nlc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .result   (result),
        .room     (out_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A class code outside text, integer and decimal never leaves the block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == CLASS_TEXT || m_tdata[1:0] == CLASS_INTEGER
                      || m_tdata[1:0] == CLASS_DECIMAL))
        else $error("invalid value_class on result");

    // Only integer results carry a nonzero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != CLASS_INTEGER) |-> (m_tdata[33:2] == '0))
        else $error("nonzero int_value on a non-integer result");

    // A taken result with no terminator behind it leaves the output empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !out_load) |=> !m_tvalid)
        else $error("result repeated after it was taken");

    // Only a terminator can produce a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !out_load) |=> !m_tvalid)
        else $error("result appeared without a terminator");

endmodule

`default_nettype wire

// ===== tb/tb_numeric_literal_classifier.sv =====
module tb_numeric_literal_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import nlc_pkg::*;

    // Recognizer states of the predictor. The block's own encoding is not visible
    // from outside, so the testbench keeps its own.
    typedef enum logic [3:0] {
        LIT_START,
        LIT_SIGN,
        LIT_INT,
        LIT_POINT,
        LIT_FRAC,
        LIT_EXP,
        LIT_EXP_SIGN,
        LIT_EXP_DIGIT,
        LIT_DEAD
    } lit_state_t;

    // One character word waiting to be sent. A terminator word may carry a result
    // typed in by hand. When it does, that result is checked instead of the one
    // the predictor works out.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              fixed;
        result_t           want;
    } char_word_t;

    // One row of the directed table: the token, and a typed-in result where the
    // answer is plain to see.
    typedef struct {
        string                     token;
        bit                        fixed;
        logic [CLASS_W-1:0]        value_class;
        logic signed [VALUE_W-1:0] int_value;
    } token_row_t;

    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_WORDS  = 1540;
    localparam int IDLE_PERCENT  = 21;
    // Both sides run without idling while the number of accepted words lies in
    // this window.
    localparam int BURST_FROM    = 900;
    localparam int BURST_TO      = 1200;
    // The receiver holds off once, for this many cycles, after this many words.
    localparam int HOLD_AFTER    = 500;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int WATCHDOG_MAX  = 2000;

    // The directed tokens cover the empty token, a sign alone, both integer
    // limits with and without saturation, every shape of decimal number, the
    // dead state reached in several ways, and bytes above 0x7F. The octal escapes
    // insert the bytes 0x80 and 0xFF.
    token_row_t directed_rows [DIRECTED_ROWS] = '{
        '{"",             1'b1, CLASS_TEXT,    32'sd0},
        '{"+",            1'b1, CLASS_TEXT,    32'sd0},
        '{"-",            1'b1, CLASS_TEXT,    32'sd0},
        '{"0",            1'b1, CLASS_INTEGER, 32'sd0},
        '{"2147483647",   1'b1, CLASS_INTEGER, 32'sh7FFF_FFFF},
        '{"2147483648",   1'b1, CLASS_INTEGER, 32'sh7FFF_FFFF},
        '{"-2147483648",  1'b1, CLASS_INTEGER, 32'sh8000_0000},
        '{"-99999999999", 1'b1, CLASS_INTEGER, 32'sh8000_0000},
        '{"+42",          1'b0, CLASS_TEXT,    32'sd0},
        '{"3.25",         1'b1, CLASS_DECIMAL, 32'sd0},
        '{"-.5",          1'b0, CLASS_TEXT,    32'sd0},
        '{"6e+7",         1'b0, CLASS_TEXT,    32'sd0},
        '{"1E-9",         1'b0, CLASS_TEXT,    32'sd0},
        '{"7.5e3",        1'b0, CLASS_TEXT,    32'sd0},
        '{"1.e5",         1'b0, CLASS_TEXT,    32'sd0},
        '{"12x4",         1'b1, CLASS_TEXT,    32'sd0},
        '{"9\2008",       1'b1, CLASS_TEXT,    32'sd0},
        '{"\377",         1'b1, CLASS_TEXT,    32'sd0},
        '{".5",           1'b0, CLASS_TEXT,    32'sd0},
        '{"1e",           1'b0, CLASS_TEXT,    32'sd0},
        '{"1.5.2",        1'b0, CLASS_TEXT,    32'sd0},
        '{"e5",           1'b0, CLASS_TEXT,    32'sd0}
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Words still to be sent, and the word currently offered on the input side.
    char_word_t char_words [$];
    char_word_t word_offered = '0;

    // Results the block owes, oldest first.
    result_t classes_due [$];

    // The predictor's copy of the block's state.
    lit_state_t         lit_state     = LIT_START;
    logic [VALUE_W-1:0] lit_magnitude = '0;
    logic               lit_negative  = 1'b0;

    int words_in    = 0;
    int errors      = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    numeric_literal_classifier uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Random idling on either side, switched off inside the burst window.
    function automatic bit idle_now();
        if (words_in >= BURST_FROM && words_in < BURST_TO) begin
            return 1'b0;
        end
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_digit();
        return CHAR_ZERO + CHAR_W'($urandom_range(9));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_sign();
        return $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
    endfunction

    // Adds one token and its terminator to the words to be sent. The terminator
    // carries a typed-in result only when it is given.
    task automatic queue_token(input logic [CHAR_W-1:0] chars [$], input bit fixed,
                               input result_t want);
        char_word_t w;
        foreach (chars[i]) begin
            w = '{char_code: chars[i], fixed: 1'b0, want: '0};
            char_words.push_back(w);
        end
        w = '{char_code: CHAR_TERM, fixed: fixed, want: want};
        char_words.push_back(w);
    endtask

    // Builds one random token. Most are well-formed integers or decimal numbers
    // with random content, the rest are broken on purpose or plain noise.
    task automatic queue_random_token();
        logic [CHAR_W-1:0] chars [$];
        int                pick;
        int                n;
        int                pos;
        string             lead;
        lead = "214748364";
        pick = $urandom_range(99);
        if (pick < 30) begin
            // Integer. Some are long enough to saturate, some sit right at the limit.
            if ($urandom_range(2) != 0) begin
                chars.push_back(rand_sign());
            end
            if ($urandom_range(19) == 0) begin
                for (int i = 0; i < lead.len(); i++) begin
                    chars.push_back(lead.getc(i));
                end
                chars.push_back(CHAR_ZERO + CHAR_W'($urandom_range(6, 9)));
            end else begin
                n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
                repeat (n) chars.push_back(rand_digit());
            end
        end else if (pick < 70) begin
            // Decimal number: a fraction, an exponent or both, the fraction first.
            if ($urandom_range(2) != 0) begin
                chars.push_back(rand_sign());
            end
            repeat ($urandom_range(pick < 55 ? 0 : 1, 3)) chars.push_back(rand_digit());
            if (pick < 55) begin
                chars.push_back(CHAR_DOT);
                repeat ($urandom_range(1, 3)) chars.push_back(rand_digit());
            end
            if (pick >= 55 || $urandom_range(1) != 0) begin
                chars.push_back($urandom_range(1) ? CHAR_EXP_L : CHAR_EXP_U);
                if ($urandom_range(1) != 0) begin
                    chars.push_back(rand_sign());
                end
                repeat ($urandom_range(1, 2)) chars.push_back(rand_digit());
            end
        end else if (pick < 85) begin
            // A decimal number that is then cut short, overwritten or extended.
            chars.push_back(rand_digit());
            chars.push_back(CHAR_DOT);
            chars.push_back(rand_digit());
            chars.push_back(CHAR_EXP_L);
            chars.push_back(rand_sign());
            chars.push_back(rand_digit());
            pos = $urandom_range(chars.size() - 1);
            case ($urandom_range(2))
                0: begin
                    while (chars.size() > pos) void'(chars.pop_back());
                end
                1: begin
                    chars[pos] = CHAR_W'($urandom_range(1, 255));
                end
                default: begin
                    chars.insert(pos, CHAR_W'($urandom_range(1, 255)));
                end
            endcase
        end else begin
            // Noise: any nonzero bytes, including the empty token.
            repeat ($urandom_range(5)) chars.push_back(CHAR_W'($urandom_range(1, 255)));
        end
        queue_token(chars, 1'b0, '0);
    endtask

    // Predictor: one accepted character word moves the recognizer. A terminator
    // produces the class and value and returns everything to the start state.
    task automatic advance_recognizer(input char_word_t w);
        logic [CHAR_W-1:0] ch;
        logic [63:0]       acc;
        bit                is_dig;
        bit                is_sgn;
        bit                is_dot;
        bit                is_exp;
        result_t           r;
        ch     = w.char_code;
        is_dig = ch >= CHAR_ZERO && ch <= CHAR_NINE;
        is_sgn = ch == CHAR_MINUS || ch == CHAR_PLUS;
        is_dot = ch == CHAR_DOT;
        is_exp = ch == CHAR_EXP_L || ch == CHAR_EXP_U;
        // Only the integer part feeds the magnitude, which sticks at 2^31.
        acc = lit_magnitude * 64'd10 + 64'(ch - CHAR_ZERO);
        if (ch != CHAR_TERM) begin
            case (lit_state)
                LIT_START: begin
                    if (is_sgn) begin
                        lit_negative = ch == CHAR_MINUS;
                        lit_state    = LIT_SIGN;
                    end else if (is_dig) begin
                        lit_magnitude = (acc > MAG_LIMIT) ? MAG_LIMIT : acc[VALUE_W-1:0];
                        lit_state     = LIT_INT;
                    end else begin
                        lit_state = LIT_DEAD;
                    end
                end
                LIT_SIGN, LIT_INT: begin
                    if (is_dig) begin
                        lit_magnitude = (acc > MAG_LIMIT) ? MAG_LIMIT : acc[VALUE_W-1:0];
                        lit_state     = LIT_INT;
                    end else if (is_dot) begin
                        lit_state = LIT_POINT;
                    end else if (is_exp && lit_state == LIT_INT) begin
                        lit_state = LIT_EXP;
                    end else begin
                        lit_state = LIT_DEAD;
                    end
                end
                LIT_POINT: begin
                    lit_state = is_dig ? LIT_FRAC : LIT_DEAD;
                end
                LIT_FRAC: begin
                    lit_state = is_dig ? LIT_FRAC : (is_exp ? LIT_EXP : LIT_DEAD);
                end
                LIT_EXP: begin
                    lit_state = is_sgn ? LIT_EXP_SIGN : (is_dig ? LIT_EXP_DIGIT : LIT_DEAD);
                end
                LIT_EXP_SIGN, LIT_EXP_DIGIT: begin
                    lit_state = is_dig ? LIT_EXP_DIGIT : LIT_DEAD;
                end
                default: begin
                    lit_state = LIT_DEAD;
                end
            endcase
        end else begin
            r = '0;
            if (lit_state == LIT_INT) begin
                r.value_class = CLASS_INTEGER;
                if (lit_negative) begin
                    r.int_value = VALUE_W'(0) - lit_magnitude;
                end else begin
                    r.int_value = (lit_magnitude >= MAG_LIMIT) ? POS_LIMIT : lit_magnitude;
                end
            end else if (lit_state == LIT_FRAC || lit_state == LIT_EXP_DIGIT) begin
                r.value_class = CLASS_DECIMAL;
            end
            classes_due.push_back(w.fixed ? w.want : r);
            lit_state     = LIT_START;
            lit_magnitude = '0;
            lit_negative  = 1'b0;
        end
    endtask

    // Sender. A word stays on the bus until it is taken. Between words the
    // sender may idle at random.
    always @(posedge aclk) begin
        char_word_t next_word;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (char_words.size() != 0 && !idle_now()) begin
                next_word = char_words.pop_front();
                word_offered <= next_word;
                s_tdata      <= next_word.char_code;
                s_tvalid     <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver. It stalls at random, and once holds off for a long stretch
    // while the sender keeps offering words, so that the block fills up and
    // stops taking input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && words_in >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !idle_now();
        end
    end

    // Monitor. Each accepted input word goes through the predictor. Each accepted
    // result word is compared, field by field, with the oldest owed result.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                words_in <= words_in + 1;
                advance_recognizer(word_offered);
            end
            if (m_tvalid && m_tready) begin
                if (classes_due.size() == 0) begin
                    $error("result word with no result owed: value_class %0d, int_value %0d",
                           m_tdata[CLASS_W-1:0], $signed(m_tdata[CLASS_W +: VALUE_W]));
                    errors++;
                end else begin
                    want = classes_due.pop_front();
                    if (m_tdata[CLASS_W-1:0] !== want.value_class) begin
                        $error("value_class: expected %0d, actual %0d",
                               want.value_class, m_tdata[CLASS_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[CLASS_W +: VALUE_W] !== want.int_value) begin
                        $error("int_value: expected %0d, actual %0d",
                               $signed(want.int_value),
                               $signed(m_tdata[CLASS_W +: VALUE_W]));
                        errors++;
                    end
                    if (m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
                        $error("padding: expected 0, actual %0h",
                               m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog. It counts cycles in which neither side accepts a word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_MAX) begin
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [CHAR_W-1:0] chars [$];
        result_t           want;
        int                directed_words;
        int                total_words;

        // All stimulus is queued before reset is released. The directed table
        // comes first, then random tokens.
        foreach (directed_rows[r]) begin
            chars.delete();
            for (int i = 0; i < directed_rows[r].token.len(); i++) begin
                chars.push_back(directed_rows[r].token.getc(i));
            end
            want = '{value_class: directed_rows[r].value_class,
                     int_value: directed_rows[r].int_value};
            queue_token(chars, directed_rows[r].fixed, want);
        end
        directed_words = char_words.size();
        while (char_words.size() < directed_words + RANDOM_WORDS) begin
            queue_random_token();
        end
        total_words = char_words.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every word to be taken and every owed result to arrive, then
        // wait out the drain cycles, in which a stray result would show.
        while (words_in < total_words) @(posedge aclk);
        while (classes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
